@@ src/fcsp_pkg.sv @@
// fcsp_pkg: shared types, codes and constants of the fixed-cycle signal phase block
// used by fcsp_ctrl, fcsp_datapath and fixed_cycle_signal_phase_top; no dependencies
package fcsp_pkg;

  // field widths
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MINUTE_W   = 6;
  localparam int unsigned MILLI_W    = 16;
  localparam int unsigned START_W    = 28;
  localparam int unsigned LEN_W      = 20;
  localparam int unsigned TTR_W      = 21;
  localparam int unsigned CFG_IDX_W  = 2;

  // time of day in ms fits 27 bits for any input bit pattern
  localparam int unsigned NOW_W      = 27;
  // green + yellow + red
  localparam int unsigned CYCLE_W    = 22;
  // green + yellow
  localparam int unsigned GY_W       = 21;

  localparam int unsigned MS_PER_HOUR   = 3600000;
  localparam int unsigned MS_PER_MINUTE = 60000;

  // one remainder step per dividend bit
  localparam int unsigned DIV_STEPS  = NOW_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    PHASE_GREEN   = 2'd0,
    PHASE_YELLOW  = 2'd1,
    PHASE_RED     = 2'd2,
    PHASE_UNKNOWN = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    LIGHT_UNKNOWN = 2'd0,
    LIGHT_GREEN   = 2'd1,
    LIGHT_RED     = 2'd2
  } light_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CYCLE_START = 2'd0,
    CFG_GREEN       = 2'd1,
    CFG_YELLOW      = 2'd2,
    CFG_RED         = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOW,
    ST_DELTA,
    ST_DIV,
    ST_FIX,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the input transfer
    logic calc_now;    // time of day, cycle and green+yellow sums
    logic calc_delta;  // signed offset from start, split into sign and magnitude
    logic div_step;    // one restoring remainder step
    logic fix;         // floor correction of the remainder
    logic finish;      // classify phase and load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a new result this cycle
  } status_t;

endpackage

@@ src/fixed_cycle_signal_phase_top.sv @@
// fixed_cycle_signal_phase_top: top level of the fixed-cycle signal phase predictor
// depends on fcsp_pkg, fcsp_ctrl and fcsp_datapath
//
// channel   direction  handshake                   payload
// s_axis    in         s_axis_tvalid/s_axis_tready  time of day (hour, minute, ms)
// m_axis    out        m_axis_tvalid/m_axis_tready  phase, light, change flag, timers
// cfg       in         cfg_we                       cycle start and phase lengths
//
// each item runs through the states NOW, DELTA, DIV, FIX and FINISH after its input transfer:
// setup, the serial remainder of the time offset by the cycle length, floor correction,
// classify and load of the result; the next transfer is taken only back in IDLE
// the result sits in an output register; the input is taken again while it waits
// a stalled output holds the sequencer in its last step until the register frees
// rst is synchronous: unset schedule, previous light unknown, no result pending
module fixed_cycle_signal_phase_top
  import fcsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // hour_of_day[4:0], minute_of_hour[10:5], milli_of_minute[26:11], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // schedule_valid[0], phase[2:1], light[4:3], light_changed[5],
  // time_to_change_ms[25:6], time_to_red_ms[46:26], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [START_W-1:0]    cfg_wdata
);

  cmd_t                     cmd;
  status_t                  status;
  logic                     schedule_valid;
  phase_t                   phase;
  light_t                   light;
  logic                     light_changed;
  logic [LEN_W-1:0]         time_to_change_ms;
  logic signed [TTR_W-1:0]  time_to_red_ms;

  fcsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fcsp_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .hour_of_day       (s_axis_tdata[4:0]),
    .minute_of_hour    (s_axis_tdata[10:5]),
    .milli_of_minute   (s_axis_tdata[26:11]),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .schedule_valid    (schedule_valid),
    .phase             (phase),
    .light             (light),
    .light_changed     (light_changed),
    .time_to_change_ms (time_to_change_ms),
    .time_to_red_ms    (time_to_red_ms)
  );

  // result packing, first field lowest
  assign m_axis_tdata = {1'b0, time_to_red_ms, time_to_change_ms, light_changed,
                         light, phase, schedule_valid};

endmodule

@@ src/fcsp_ctrl.sv @@
// fcsp_ctrl: sequencer of the fixed-cycle signal phase block
// depends on fcsp_pkg; drives the datapath through cmd_t and reads status_t
module fcsp_ctrl
  import fcsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] div_count;

  // state register and remainder step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DELTA) begin
        div_count <= '0;
      end else if (state == ST_DIV) begin
        div_count <= div_count + 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_NOW;
      end
      ST_NOW:   state_next = ST_DELTA;
      ST_DELTA: state_next = ST_DIV;
      ST_DIV: begin
        if (div_count == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_FIX;
      end
      ST_FIX: state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_NOW:    cmd.calc_now   = 1'b1;
      ST_DELTA:  cmd.calc_delta = 1'b1;
      ST_DIV:    cmd.div_step   = 1'b1;
      ST_FIX:    cmd.fix        = 1'b1;
      ST_FINISH: cmd.finish     = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ src/fcsp_datapath.sv @@
// fcsp_datapath: configuration registers, time arithmetic, serial remainder and
// output register of the fixed-cycle signal phase block; depends on fcsp_pkg
module fcsp_datapath
  import fcsp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  cmd_t                        cmd,
  output status_t                     status,
  // configuration writes
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [START_W-1:0]          cfg_wdata,
  // input fields
  input  logic [HOUR_W-1:0]           hour_of_day,
  input  logic [MINUTE_W-1:0]         minute_of_hour,
  input  logic [MILLI_W-1:0]          milli_of_minute,
  // result register
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        schedule_valid,
  output phase_t                      phase,
  output light_t                      light,
  output logic                        light_changed,
  output logic [LEN_W-1:0]            time_to_change_ms,
  output logic signed [TTR_W-1:0]     time_to_red_ms
);

  // configuration
  logic signed [START_W-1:0] cycle_start_ms;
  logic [LEN_W-1:0]          green_ms;
  logic [LEN_W-1:0]          yellow_ms;
  logic [LEN_W-1:0]          red_ms;

  // working registers
  logic [HOUR_W-1:0]   hour_r;
  logic [MINUTE_W-1:0] minute_r;
  logic [MILLI_W-1:0]  milli_r;
  logic [NOW_W-1:0]    now_ms;
  logic [CYCLE_W-1:0]  cycle_ms;
  logic [GY_W-1:0]     gy_ms;
  logic                delta_neg;
  logic [NOW_W-1:0]    div_mag;
  logic [CYCLE_W-1:0]  div_rem;
  logic [CYCLE_W-1:0]  pos_ms;
  light_t              prev_light;

  logic [START_W-1:0]  delta;
  logic [CYCLE_W:0]    rem_shift;
  logic [CYCLE_W+1:0]  rem_diff;
  logic                sched_ok;
  logic                in_green;
  logic                in_yellow;
  logic [CYCLE_W-1:0]  phase_end;
  logic [CYCLE_W-1:0]  left_ms;
  phase_t              phase_d;
  light_t              light_d;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_start_ms <= '1;
      green_ms       <= '0;
      yellow_ms      <= '0;
      red_ms         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CYCLE_START: cycle_start_ms <= cfg_wdata;
        CFG_GREEN:       green_ms       <= cfg_wdata[LEN_W-1:0];
        CFG_YELLOW:      yellow_ms      <= cfg_wdata[LEN_W-1:0];
        CFG_RED:         red_ms         <= cfg_wdata[LEN_W-1:0];
        default:         ;
      endcase
    end
  end

  assign sched_ok = !cycle_start_ms[START_W-1] && (green_ms != '0) &&
                    (yellow_ms != '0) && (red_ms != '0);

  // offset from start; start is nonnegative whenever the result is used
  assign delta = {1'b0, now_ms} - cycle_start_ms;

  // restoring remainder step
  assign rem_shift = {div_rem, div_mag[NOW_W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, cycle_ms};

  // phase classification of the position within the cycle
  assign in_green  = pos_ms < {2'b00, green_ms};
  assign in_yellow = pos_ms < {1'b0, gy_ms};

  always_comb begin
    if (in_green) begin
      phase_end = {2'b00, green_ms};
      phase_d   = PHASE_GREEN;
      light_d   = LIGHT_GREEN;
    end else if (in_yellow) begin
      phase_end = {1'b0, gy_ms};
      phase_d   = PHASE_YELLOW;
      light_d   = LIGHT_GREEN;
    end else begin
      phase_end = cycle_ms;
      phase_d   = PHASE_RED;
      light_d   = LIGHT_RED;
    end
    if (!sched_ok) begin
      phase_d = PHASE_UNKNOWN;
      light_d = LIGHT_UNKNOWN;
    end
  end

  assign left_ms = phase_end - pos_ms;

  // arithmetic sequence
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hour_r   <= hour_of_day;
      minute_r <= minute_of_hour;
      milli_r  <= milli_of_minute;
    end
    if (cmd.calc_now) begin
      now_ms   <= NOW_W'(hour_r) * NOW_W'(MS_PER_HOUR) +
                  NOW_W'(minute_r) * NOW_W'(MS_PER_MINUTE) + NOW_W'(milli_r);
      cycle_ms <= CYCLE_W'(green_ms) + CYCLE_W'(yellow_ms) + CYCLE_W'(red_ms);
      gy_ms    <= GY_W'(green_ms) + GY_W'(yellow_ms);
    end
    if (cmd.calc_delta) begin
      delta_neg <= delta[START_W-1];
      div_mag   <= delta[START_W-1] ? NOW_W'(-delta) : delta[NOW_W-1:0];
      div_rem   <= '0;
    end
    if (cmd.div_step) begin
      div_mag <= {div_mag[NOW_W-2:0], 1'b0};
      div_rem <= rem_diff[CYCLE_W+1] ? rem_shift[CYCLE_W-1:0] : rem_diff[CYCLE_W-1:0];
    end
    // floor modulo: a negative offset with a nonzero remainder wraps into the cycle
    if (cmd.fix) begin
      pos_ms <= (delta_neg && (div_rem != '0)) ? (cycle_ms - div_rem) : div_rem;
    end
  end

  // output register and last reported light
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_light <= LIGHT_UNKNOWN;
    end else begin
      if (cmd.finish) begin
        out_valid  <= 1'b1;
        prev_light <= light_d;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      schedule_valid    <= sched_ok;
      phase             <= phase_d;
      light             <= light_d;
      light_changed     <= light_d != prev_light;
      time_to_change_ms <= sched_ok ? left_ms[LEN_W-1:0] : '0;
      time_to_red_ms    <= (sched_ok && in_green) ? {1'b0, left_ms[LEN_W-1:0]} : '1;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

@@ sim/tb_fixed_cycle_signal_phase_top.sv @@
`timescale 1ns / 1ps
// tb_fixed_cycle_signal_phase_top: self-checking testbench of the fixed-cycle signal phase block
// depends on fcsp_pkg and fixed_cycle_signal_phase_top; predicts phase, light and timers per tick
module tb_fixed_cycle_signal_phase_top;
  import fcsp_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned MS_PER_DAY  = 86400000;
  localparam int unsigned RUN_TICKS   = 190;
  localparam int unsigned RUN_PHASES  = 10;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [MILLI_W-1:0]  milli;
  } tick_t;

  typedef struct packed {
    logic              valid;
    phase_t            phase;
    light_t            light;
    logic              changed;
    logic [LEN_W-1:0]  to_change;
    logic [TTR_W-1:0]  to_red;
  } signal_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CYCLE_START;
  logic [START_W-1:0]    cfg_wdata = '0;

  fixed_cycle_signal_phase_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // shadow schedule and light history
  logic signed [START_W-1:0] sched_start = -1;
  logic [LEN_W-1:0]          green_len = '0;
  logic [LEN_W-1:0]          yellow_len = '0;
  logic [LEN_W-1:0]          red_len = '0;
  light_t                    last_light = LIGHT_UNKNOWN;

  tick_t   tick_q[$];
  signal_t signal_q[$];
  int      mismatches = 0;
  int      stall_cnt = 0;
  bit      idle_on = 1'b1;
  bit      in_taken = 1'b0;
  int      hold_asks = 0;
  int      hold_seen = 0;
  int      hold_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // phase, light and timers for one tick under the shadow schedule
  function automatic signal_t predict_signal(tick_t t);
    signal_t r;
    longint  now_ms;
    longint  offset;
    longint  period;
    longint  pos;
    r.valid     = 1'b0;
    r.phase     = PHASE_UNKNOWN;
    r.light     = LIGHT_UNKNOWN;
    r.to_change = '0;
    r.to_red    = '1;
    if (sched_start >= 0 && green_len != 0 && yellow_len != 0 && red_len != 0) begin
      now_ms = longint'(t.hour) * MS_PER_HOUR + longint'(t.minute) * MS_PER_MINUTE
             + longint'(t.milli);
      offset = now_ms - longint'(sched_start);
      period = longint'(green_len) + longint'(yellow_len) + longint'(red_len);
      pos = offset % period;
      // floor modulo: times before the start fold into the cycle
      if (pos < 0) pos += period;
      r.valid = 1'b1;
      if (pos < longint'(green_len)) begin
        r.phase     = PHASE_GREEN;
        r.light     = LIGHT_GREEN;
        r.to_change = LEN_W'(longint'(green_len) - pos);
        r.to_red    = TTR_W'(longint'(green_len) - pos);
      end else if (pos < longint'(green_len) + longint'(yellow_len)) begin
        r.phase     = PHASE_YELLOW;
        r.light     = LIGHT_GREEN;
        r.to_change = LEN_W'(longint'(green_len) + longint'(yellow_len) - pos);
      end else begin
        r.phase     = PHASE_RED;
        r.light     = LIGHT_RED;
        r.to_change = LEN_W'(period - pos);
      end
    end
    r.changed  = (r.light != last_light);
    last_light = r.light;
    return r;
  endfunction

  function automatic tick_t make_tick(int unsigned h, int unsigned m, int unsigned ms);
    tick_t t;
    t.hour   = HOUR_W'(h);
    t.minute = MINUTE_W'(m);
    t.milli  = MILLI_W'(ms);
    return t;
  endfunction

  // append one tick to the pending queue
  function automatic void queue_tick(tick_t t);
    tick_q.insert(tick_q.size(), t);
  endfunction

  // ticks that advance like a real clock, mixed with raw noise over the full field widths
  task automatic add_traffic(int unsigned n);
    int unsigned day_ms;
    day_ms = $urandom_range(0, MS_PER_DAY - 1);
    repeat (n) begin
      if ($urandom_range(0, 99) < 20) begin
        queue_tick(make_tick($urandom_range(0, 31), $urandom_range(0, 63),
                             $urandom_range(0, 65535)));
      end else begin
        if ($urandom_range(0, 99) < 5) day_ms = $urandom_range(0, MS_PER_DAY - 1);
        else day_ms = (day_ms + $urandom_range(0, 120)) % MS_PER_DAY;
        queue_tick(make_tick(day_ms / MS_PER_HOUR, (day_ms % MS_PER_HOUR) / MS_PER_MINUTE,
                             day_ms % MS_PER_MINUTE));
      end
    end
  endtask

  // wait until every tick has been sent and every result has come back
  task automatic settle();
    do @(posedge clk);
    while (tick_q.size() != 0 || s_axis_tvalid || signal_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [START_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CYCLE_START: sched_start = val;
      CFG_GREEN:       green_len   = val[LEN_W-1:0];
      CFG_YELLOW:      yellow_len  = val[LEN_W-1:0];
      CFG_RED:         red_len     = val[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_schedule(logic [START_W-1:0] start, logic [LEN_W-1:0] g,
                              logic [LEN_W-1:0] y, logic [LEN_W-1:0] r);
    cfg_write(CFG_CYCLE_START, start);
    cfg_write(CFG_GREEN, START_W'(g));
    cfg_write(CFG_YELLOW, START_W'(y));
    cfg_write(CFG_RED, START_W'(r));
  endtask

  // stimulus sequence
  initial begin
    int unsigned ph;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // schedule unset after reset
    queue_tick(make_tick(0, 0, 0));
    queue_tick(make_tick(31, 63, 65535));
    queue_tick(make_tick(12, 30, 30000));
    settle();

    // partial schedule stays unset
    cfg_write(CFG_CYCLE_START, START_W'(1000));
    queue_tick(make_tick(0, 0, 1000));
    settle();
    cfg_write(CFG_GREEN, START_W'(5000));
    cfg_write(CFG_YELLOW, START_W'(2000));
    queue_tick(make_tick(0, 0, 1000));
    settle();

    // phase boundaries, time before start and out-of-range fields
    cfg_write(CFG_RED, START_W'(3000));
    queue_tick(make_tick(0, 0, 0));
    queue_tick(make_tick(0, 0, 1000));
    queue_tick(make_tick(0, 0, 5999));
    queue_tick(make_tick(0, 0, 6000));
    queue_tick(make_tick(0, 0, 7999));
    queue_tick(make_tick(0, 0, 8000));
    queue_tick(make_tick(0, 0, 10999));
    queue_tick(make_tick(0, 0, 11000));
    queue_tick(make_tick(23, 59, 59999));
    queue_tick(make_tick(31, 63, 65535));
    settle();

    // most negative start means unset again
    cfg_write(CFG_CYCLE_START, 28'h8000000);
    queue_tick(make_tick(1, 2, 3));
    settle();

    // start beyond one day with the longest phases
    set_schedule(28'h7FFFFFF, '1, '1, '1);
    queue_tick(make_tick(0, 0, 0));
    queue_tick(make_tick(31, 63, 65535));
    settle();

    // shortest phases
    set_schedule('0, 20'd1, 20'd1, 20'd1);
    for (int i = 0; i < 4; i++) queue_tick(make_tick(0, 0, i));
    settle();

    // random schedules with clock-like traffic
    for (ph = 0; ph < RUN_PHASES; ph++) begin
      case (ph)
        5:       set_schedule(START_W'($urandom_range(0, MS_PER_DAY - 1)), '1, '1, '1);
        6:       set_schedule(START_W'($urandom_range(0, 2000)),
                              LEN_W'($urandom_range(1, 4)),
                              LEN_W'($urandom_range(1, 4)), LEN_W'($urandom_range(1, 4)));
        7:       set_schedule(START_W'($urandom_range(0, MS_PER_DAY - 1)),
                              LEN_W'($urandom_range(1, 3000)),
                              LEN_W'($urandom_range(1, 3000)), '0);
        8:       set_schedule(28'h8000000 | START_W'($urandom()),
                              LEN_W'($urandom_range(1, 3000)),
                              LEN_W'($urandom_range(1, 3000)),
                              LEN_W'($urandom_range(1, 3000)));
        default: set_schedule(START_W'($urandom_range(0, MS_PER_DAY - 1)),
                              LEN_W'($urandom_range(1, 3000)),
                              LEN_W'($urandom_range(1, 3000)),
                              LEN_W'($urandom_range(1, 3000)));
      endcase
      // one run without idling, one with a long receiver hold-off
      idle_on = (ph != 1);
      if (ph == 3) hold_asks++;
      add_traffic(RUN_TICKS);
      settle();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && signal_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // tick sender
  always @(negedge clk) begin
    tick_t t;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (tick_q.size() != 0 && !(idle_on && $urandom_range(0, 99) < 7)) begin
        t = tick_q.pop_front();
        s_axis_tdata  <= IN_DATA_W'({t.milli, t.minute, t.hour});
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and the long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 7);
    end
  end

  // check results against the oldest prediction, predict on each tick transfer
  always @(posedge clk) begin
    signal_t exp_sig;
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (signal_q.size() == 0) begin
          $error("result transfer with no prediction pending");
          mismatches++;
        end else begin
          exp_sig = signal_q.pop_front();
          if (m_axis_tdata[0] !== exp_sig.valid) begin
            $error("schedule_valid: expected %0d, got %0d", exp_sig.valid, m_axis_tdata[0]);
            mismatches++;
          end
          if (m_axis_tdata[2:1] !== exp_sig.phase) begin
            $error("phase: expected %0d, got %0d", exp_sig.phase, m_axis_tdata[2:1]);
            mismatches++;
          end
          if (m_axis_tdata[4:3] !== exp_sig.light) begin
            $error("light: expected %0d, got %0d", exp_sig.light, m_axis_tdata[4:3]);
            mismatches++;
          end
          if (m_axis_tdata[5] !== exp_sig.changed) begin
            $error("light_changed: expected %0d, got %0d", exp_sig.changed, m_axis_tdata[5]);
            mismatches++;
          end
          if (m_axis_tdata[25:6] !== exp_sig.to_change) begin
            $error("time_to_change_ms: expected %0d, got %0d", exp_sig.to_change,
                   m_axis_tdata[25:6]);
            mismatches++;
          end
          if (m_axis_tdata[46:26] !== exp_sig.to_red) begin
            $error("time_to_red_ms: expected %0d, got %0d", $signed(exp_sig.to_red),
                   $signed(m_axis_tdata[46:26]));
            mismatches++;
          end
        end
      end
      // unpack hour, minute and ms from their lowest-first places in tdata
      if (s_axis_tvalid && s_axis_tready) begin
        signal_q.insert(signal_q.size(), predict_signal(tick_t'({
          s_axis_tdata[HOUR_W-1:0],
          s_axis_tdata[HOUR_W+MINUTE_W-1:HOUR_W],
          s_axis_tdata[HOUR_W+MINUTE_W+MILLI_W-1:HOUR_W+MINUTE_W]})));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

endmodule

@@ fixed_cycle_signal_phase_top.f @@
src/fcsp_pkg.sv
src/fcsp_ctrl.sv
src/fcsp_datapath.sv
src/fixed_cycle_signal_phase_top.sv
sim/tb_fixed_cycle_signal_phase_top.sv
